>>> sv/axfcs_pkg.sv
// Package: shared types, constants and the CRC step for the AX.25 check-field builder.
`default_nettype none
package axfcs_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned POS_W     = 7;
	localparam int unsigned CRC_W     = 16;
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);
	localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [CRC_W-1:0]  CRC_START      = 16'hFFFF;
	localparam logic [POS_W-1:0]  ADDR_LEN_RESET = 7'd21;
	localparam logic [BYTE_W-1:0] ADDR_END_BIT   = 8'h01;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              frame_end;
		logic [CRC_W-1:0]  fcs;
	} entry_t;

	// reflected CRC-16-CCITT, one byte
	function automatic logic [CRC_W-1:0] fcs_update(input logic [CRC_W-1:0] acc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] t;
		t = b ^ acc[7:0];
		t = t ^ {t[3:0], 4'b0000};
		return {t, acc[15:8]} ^ {12'b0, t[7:4]} ^ {5'b0, t, 3'b000};
	endfunction

endpackage
`default_nettype wire

>>> sv/ax25_frame_fcs_builder_unit.sv
// Top level: AX.25 frame byte shaper and check-field builder.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  cfg     | cfg_wr_en, cfg_wr_data[6:0]              | in
//  in      | in_valid, in_ready, data_byte, frame_end | in
//  out     | out_valid, out_ready, out_byte, out_last | out
//
// One request per cycle in while in_ready is high, one result byte per cycle out while
// out_ready is high; a frame-end byte yields three results. The four-entry queue
// between front and back absorbs these bursts; in_ready drops only when it is full.
// Reset is asynchronous: CRC to 0xFFFF, position to zero, address length to 21.
`default_nettype none
module ax25_frame_fcs_builder_unit import axfcs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [POS_W-1:0]  cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              frame_end,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   out_last
);

	entry_t             push_entry;
	entry_t             head;
	logic               push;
	logic               pop;
	logic               q_empty;
	logic               q_full;
	logic [QCNT_W-1:0]  q_count;

	axfcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	axfcs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full),
		.count     (q_count)
	);

	axfcs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.out_last (out_last)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_count != '0)
		else $error("pop from empty queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> q_count == $past(q_count) + QCNT_W'(1))
		else $error("queue count did not follow push");
`endif

endmodule
`default_nettype wire

>>> sv/axfcs_front.sv
// Front end: address shifting, position tracking and running CRC per accepted byte.
`default_nettype none
module axfcs_front import axfcs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [POS_W-1:0]  cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              frame_end,
	input  wire logic              q_full,
	output logic                   push,
	output entry_t                 push_entry
);

	logic [POS_W-1:0]  addr_len_q;
	logic [POS_W-1:0]  pos_q;
	logic [CRC_W-1:0]  crc_q;
	logic [BYTE_W-1:0] b;
	logic [POS_W-1:0]  pos_next;
	logic [CRC_W-1:0]  crc_next;
	logic              in_addr;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign in_addr  = pos_q < addr_len_q;

	always_comb begin
		b        = data_byte;
		pos_next = pos_q;
		if (in_addr) begin
			b = {data_byte[6:0], 1'b0};
			if ((pos_q + POS_W'(1)) == addr_len_q)
				b = b | ADDR_END_BIT;
			pos_next = pos_q + POS_W'(1);
		end
		crc_next = fcs_update(crc_q, b);
	end

	assign push_entry.data      = b;
	assign push_entry.frame_end = frame_end;
	assign push_entry.fcs       = ~crc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_len_q <= ADDR_LEN_RESET;
			pos_q      <= '0;
			crc_q      <= CRC_START;
		end else begin
			if (cfg_wr_en)
				addr_len_q <= cfg_wr_data;
			if (push) begin
				if (frame_end) begin
					pos_q <= '0;
					crc_q <= CRC_START;
				end else begin
					pos_q <= pos_next;
					crc_q <= crc_next;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/axfcs_queue.sv
// Short queue between front and back end.
`default_nettype none
module axfcs_queue import axfcs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire entry_t            push_entry,
	input  wire logic              pop,
	output entry_t                 head,
	output logic                   empty,
	output logic                   full,
	output logic [QCNT_W-1:0]      count
);

	entry_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign count = count_q;
	assign empty = count_q == '0;
	assign full  = count_q == QCNT_W'(QDEPTH);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule
`default_nettype wire

>>> sv/axfcs_back.sv
// Back end: output register, sends frame bytes and the two check-field bytes.
`default_nettype none
module axfcs_back import axfcs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire entry_t            head,
	input  wire logic              empty,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   out_last
);

	typedef enum logic [1:0] {
		PH_DATA,
		PH_FCS_LO,
		PH_FCS_HI
	} phase_t;

	phase_t             phase_q;
	logic               valid_q;
	logic [BYTE_W-1:0]  byte_q;
	logic               last_q;
	logic [CRC_W-1:0]   fcs_q;
	logic               load;

	assign load      = !valid_q || out_ready;
	assign pop       = load && (phase_q == PH_DATA) && !empty;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			byte_q  <= '0;
			fcs_q   <= '0;
		end else if (load) begin
			case (phase_q)
				PH_FCS_LO: begin
					byte_q  <= fcs_q[7:0];
					last_q  <= 1'b0;
					valid_q <= 1'b1;
					phase_q <= PH_FCS_HI;
				end
				PH_FCS_HI: begin
					byte_q  <= fcs_q[15:8];
					last_q  <= 1'b1;
					valid_q <= 1'b1;
					phase_q <= PH_DATA;
				end
				default: begin
					last_q  <= 1'b0;
					valid_q <= !empty;
					if (!empty) begin
						byte_q <= head.data;
						fcs_q  <= head.fcs;
						if (head.frame_end)
							phase_q <= PH_FCS_LO;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench: predicts shaped frame bytes and check fields and compares each result.
`timescale 1ns / 1ps
module tb_top;
	import axfcs_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} tx_byte_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [POS_W-1:0]  cfg_wr_data = '0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] data_byte   = '0;
	logic              frame_end   = 1'b0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic              out_last;

	tx_byte_t          pending_tx[$];
	tx_byte_t          head;
	logic [CRC_W-1:0]  crc_acc;
	logic [POS_W-1:0]  pos_count;
	logic [POS_W-1:0]  addr_len;
	int                send_idle   = 0;
	int                recv_idle   = 0;
	int unsigned       errors      = 0;
	int unsigned       cycle_count = 0;

	ax25_frame_fcs_builder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// bitwise reflected CRC-16-CCITT, poly 0x8408
	function automatic logic [CRC_W-1:0] crc_x25_byte(input logic [CRC_W-1:0] c,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] r;
		r = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
		return r;
	endfunction

	task automatic shape_and_fcs(input logic [BYTE_W-1:0] d, input logic e);
		logic [BYTE_W-1:0] b;
		logic [CRC_W-1:0]  fcs;
		b = d;
		if (pos_count < addr_len) begin
			b = {d[6:0], 1'b0};
			if ({1'b0, pos_count} + 8'd1 == {1'b0, addr_len})
				b[0] = 1'b1;
			pos_count = pos_count + 7'd1;
		end
		crc_acc = crc_x25_byte(crc_acc, b);
		pending_tx.push_back('{data: b, last: 1'b0});
		if (e) begin
			fcs = ~crc_acc;
			pending_tx.push_back('{data: fcs[7:0], last: 1'b0});
			pending_tx.push_back('{data: fcs[15:8], last: 1'b1});
			crc_acc   = CRC_START;
			pos_count = '0;
		end
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] d, input logic e);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= d;
		frame_end <= e;
		do @(posedge clk); while (!in_ready);
		shape_and_fcs(d, e);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_tx.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_addr_len(input logic [POS_W-1:0] v);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		addr_len = v;
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_tx.size() == 0) begin
				$error("out_byte: expected none, actual %h", out_byte);
				errors++;
			end else begin
				head = pending_tx.pop_front();
				if (out_byte !== head.data) begin
					$error("out_byte: expected %h, actual %h", head.data, out_byte);
					errors++;
				end
				if (out_last !== head.last) begin
					$error("out_last: expected %b, actual %b", head.last, out_last);
					errors++;
				end
			end
		end
	end

	// reset length, frame ends inside the address
	task automatic test_reset_length();
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	task automatic test_zero_length();
		write_addr_len(7'd0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b1);
	endtask

	// end mark on the last address byte, then payload
	task automatic test_short_lengths();
		write_addr_len(7'd1);
		send_byte(8'hFF, 1'b1);
		write_addr_len(7'd2);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h7F, 1'b1);
	endtask

	task automatic test_max_length();
		write_addr_len(7'd127);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
	endtask

	task automatic test_length_change_mid_frame();
		write_addr_len(7'd14);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'h43, 1'b0);
		write_addr_len(7'd2);
		send_byte(8'h44, 1'b0);
		send_byte(8'h45, 1'b1);
	endtask

	task automatic test_random_frames(input int s_idle, input int r_idle, input int n_items);
		int sent;
		int len;
		int pick;
		sent      = 0;
		send_idle = s_idle;
		recv_idle = r_idle;
		while (sent < n_items) begin
			if ($urandom_range(3) == 0) begin
				pick = $urandom_range(9);
				if (pick < 3)
					write_addr_len(7'd14);
				else if (pick == 3)
					write_addr_len(7'd70);
				else
					write_addr_len(7'($urandom_range(70, 14)));
			end
			if ($urandom_range(99) < 80)
				len = int'(addr_len) + $urandom_range(6);
			else
				len = $urandom_range((addr_len > 0) ? int'(addr_len) : 1, 1);
			if (len > n_items - sent)
				len = n_items - sent;
			for (int k = 0; k < len; k++) begin
				send_byte(8'($urandom_range(255)), k == len - 1);
				sent++;
			end
		end
	endtask

	initial begin
		crc_acc   = CRC_START;
		pos_count = '0;
		addr_len  = ADDR_LEN_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 19;
		recv_idle = 58;
		test_reset_length();
		test_zero_length();
		test_short_lengths();
		test_max_length();
		test_length_change_mid_frame();

		test_random_frames(19, 58, 85);
		test_random_frames(58, 19, 85);
		test_random_frames(0, 0, 85);

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
